// ===== hw/rtl/pfrc_pkg.sv =====
// Shared types and constants of the packet frame reassembly coalescer.
package pfrc_pkg;

  localparam int unsigned SrcAddrW   = 48;
  localparam int unsigned PayLenW    = 16;
  localparam int unsigned RunW       = 33;
  localparam int unsigned CfgDataW   = 32;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned InDataW    = 64;
  localparam int unsigned OutDataW   = 120;

  localparam logic [31:0] FrameSizeReset = 32'd6220800;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FRAME_SIZE   = 1'b0,
    REG_COPY_TO_HOST = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ERR_NONE           = 2'd0,
    ERR_OVERFLOW       = 2'd1,
    ERR_FULL_NO_MARKER = 2'd2,
    ERR_MARKER_EARLY   = 2'd3
  } err_code_e;

  typedef struct packed {
    logic                copy_valid;
    logic [SrcAddrW-1:0] copy_src_addr;
    logic [31:0]         copy_dest_offset;
    logic [31:0]         copy_len;
    logic                copy_host;
    logic                frame_done;
    err_code_e           error_code;
    logic                last_result;
  } result_t;

  // Results that one item pushes into the result queue, first in slot 0.
  typedef struct packed {
    logic [1:0]       count;
    result_t [1:0]    res;
  } push_t;

endpackage

// ===== hw/rtl/pfrc_engine.sv =====
// Input register and per-item run coalescing and frame checking logic.
module pfrc_engine #(
  parameter int ADDR_BITS = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [pfrc_pkg::SrcAddrW-1:0] in_addr_i,
  input  logic [pfrc_pkg::PayLenW-1:0]  in_len_i,
  input  logic                          in_marker_i,
  input  logic [31:0]                   frame_size_i,
  input  logic                          copy_to_host_i,
  input  logic                          room_i,
  output pfrc_pkg::push_t               push_o
);
  import pfrc_pkg::*;

  localparam logic [SrcAddrW:0] AdjMask = (ADDR_BITS >= SrcAddrW + 1) ?
      {(SrcAddrW + 1){1'b1}} : (({{SrcAddrW{1'b0}}, 1'b1} << ADDR_BITS) - 1'b1);
  localparam logic [SrcAddrW-1:0] AddrMask = AdjMask[SrcAddrW-1:0];

  logic                valid_q, valid_d;
  logic [SrcAddrW-1:0] addr_q;
  logic [PayLenW-1:0]  len_q;
  logic                marker_q;

  logic                resync_q, resync_d;
  logic                run_valid_q, run_valid_d;
  logic [SrcAddrW-1:0] run_addr_q, run_addr_d;
  logic [RunW-1:0]     run_len_q, run_len_d;
  logic [RunW-1:0]     frame_off_q, frame_off_d;

  logic                fire;
  logic [SrcAddrW-1:0] addr_m;
  logic [SrcAddrW-1:0] start;
  logic [SrcAddrW:0]   run_end;
  logic                flush;
  logic [RunW-1:0]     off1;
  logic [SrcAddrW-1:0] addr1;
  logic [RunW-1:0]     len1;
  logic [RunW:0]       used;
  logic [RunW:0]       fsize;
  err_code_e           err;
  result_t             flush_res;
  result_t             tail_res;
  logic                tail_en;

  assign fire       = valid_q & room_i;
  assign in_ready_o = ~valid_q | room_i;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (fire) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      addr_q   <= in_addr_i;
      len_q    <= in_len_i;
      marker_q <= in_marker_i;
    end
  end

  always_comb begin
    addr_m  = addr_q & AddrMask;
    start   = run_valid_q ? run_addr_q : addr_m;
    run_end = ({1'b0, start} + {{(SrcAddrW - RunW + 1){1'b0}}, run_len_q}) & AdjMask;
    flush   = (run_end != {1'b0, addr_m});
    off1    = flush ? (frame_off_q + run_len_q) : frame_off_q;
    addr1   = flush ? addr_m : start;
    len1    = (flush ? '0 : run_len_q) + {{(RunW - PayLenW){1'b0}}, len_q};
    used    = {1'b0, off1} + {1'b0, len1};
    fsize   = {{(RunW + 1 - 32){1'b0}}, frame_size_i};

    if (used > fsize) begin
      err = ERR_OVERFLOW;
    end else if (used == fsize && !marker_q) begin
      err = ERR_FULL_NO_MARKER;
    end else if (used != fsize && marker_q) begin
      err = ERR_MARKER_EARLY;
    end else begin
      err = ERR_NONE;
    end
    tail_en = (err != ERR_NONE) || marker_q;

    flush_res.copy_valid       = 1'b1;
    flush_res.copy_src_addr    = start;
    flush_res.copy_dest_offset = frame_off_q[31:0];
    flush_res.copy_len         = run_len_q[31:0];
    flush_res.copy_host        = copy_to_host_i;
    flush_res.frame_done       = 1'b0;
    flush_res.error_code       = ERR_NONE;
    flush_res.last_result      = ~tail_en;

    if (err != ERR_NONE) begin
      tail_res.copy_valid       = 1'b0;
      tail_res.copy_src_addr    = '0;
      tail_res.copy_dest_offset = '0;
      tail_res.copy_len         = '0;
      tail_res.copy_host        = 1'b0;
      tail_res.frame_done       = 1'b0;
    end else begin
      tail_res.copy_valid       = 1'b1;
      tail_res.copy_src_addr    = addr1;
      tail_res.copy_dest_offset = off1[31:0];
      tail_res.copy_len         = len1[31:0];
      tail_res.copy_host        = copy_to_host_i;
      tail_res.frame_done       = 1'b1;
    end
    tail_res.error_code  = err;
    tail_res.last_result = 1'b1;

    // The queue only takes the count of slots that hold results.
    push_o.count  = 2'd0;
    push_o.res[0] = flush ? flush_res : tail_res;
    push_o.res[1] = tail_res;
    if (fire && !resync_q) begin
      push_o.count = {1'b0, flush} + {1'b0, tail_en};
    end

    resync_d    = resync_q;
    run_valid_d = run_valid_q;
    run_addr_d  = run_addr_q;
    run_len_d   = run_len_q;
    frame_off_d = frame_off_q;
    if (fire) begin
      if (resync_q) begin
        if (marker_q) begin
          resync_d    = 1'b0;
          run_valid_d = 1'b0;
          run_addr_d  = '0;
          run_len_d   = '0;
          frame_off_d = '0;
        end
      end else if (marker_q) begin
        run_valid_d = 1'b0;
        run_addr_d  = '0;
        run_len_d   = '0;
        frame_off_d = '0;
      end else begin
        resync_d    = (err != ERR_NONE);
        run_valid_d = 1'b1;
        run_addr_d  = addr1;
        run_len_d   = len1;
        frame_off_d = off1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resync_q    <= 1'b0;
      run_valid_q <= 1'b0;
      run_addr_q  <= '0;
      run_len_q   <= '0;
      frame_off_q <= '0;
    end else begin
      resync_q    <= resync_d;
      run_valid_q <= run_valid_d;
      run_addr_q  <= run_addr_d;
      run_len_q   <= run_len_d;
      frame_off_q <= frame_off_d;
    end
  end

endmodule

// ===== hw/rtl/pfrc_out_fifo.sv =====
// Four-entry result queue that takes up to two results per cycle.
module pfrc_out_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pfrc_pkg::push_t   push_i,
  output logic              room_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pfrc_pkg::result_t out_res_o
);
  import pfrc_pkg::*;

  result_t    mem_q [4];
  logic [1:0] wptr_q, wptr_d;
  logic [1:0] rptr_q, rptr_d;
  logic [2:0] count_q, count_d;
  logic       pop;

  assign out_valid_o = (count_q != 3'd0);
  assign out_res_o   = mem_q[rptr_q];
  assign pop         = out_valid_o & out_ready_i;
  // Room for a full two-result push, whatever the output side does.
  assign room_o      = (count_q <= 3'd2);

  always_comb begin
    wptr_d  = wptr_q + push_i.count;
    rptr_d  = rptr_q + {1'b0, pop};
    count_d = count_q + {1'b0, push_i.count} - {2'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wptr_q] <= push_i.res[0];
    end
    if (push_i.count == 2'd2) begin
      mem_q[wptr_q + 2'd1] <= push_i.res[1];
    end
  end

endmodule

// ===== hw/rtl/packet_frame_reassembly_coalescer_core.sv =====
// Top level of the packet frame reassembly coalescer.
//
// Each input item is one packet descriptor (payload address, payload length,
// end-of-frame marker on tlast). Payloads that lie end to end in memory are
// merged into one pending run; a payload that does not continue the run makes
// the block emit a copy command for the run. A marker arriving exactly when the
// frame holds frame_size bytes emits the final copy with frame_done set. An
// overflow, a full frame without a marker, or a marker before the frame is full
// emits an error result and drops the pending run: with a marker the frame
// restarts at once, without one the following packets are skipped up to and
// including the next marker. An item causes zero, one or two results; tlast on
// the result side marks the last result of an item. The block accepts one item
// per clock cycle while the result queue has room: an item is held in an input
// register, passes one round of add and compare logic and is written into a
// four-entry result queue, whose head is offered on the result port. The
// result port delivers one result per cycle while m_axis_tready is high, so
// the two results of an item leave one after the other, and input is held off
// only while the queue holds more than two results. Configuration is written
// through a plain write port; the user must write it only while the block is
// idle, and the block itself does not enforce this.
module packet_frame_reassembly_coalescer_core #(
  parameter int ADDR_BITS = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [pfrc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pfrc_pkg::CfgDataW-1:0] cfg_wdata_i,
  // Packet descriptor items.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: payload_addr[47:0], payload_len[63:48].
  input  logic [pfrc_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic                          s_axis_tlast,
  // Result items.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata: copy_src_addr[47:0], copy_dest_offset[79:48], copy_len[111:80],
  // copy_host[112], frame_done[113], error_code[115:114], zero fill above.
  output logic [pfrc_pkg::OutDataW-1:0] m_axis_tdata,
  // tuser: copy_valid[0].
  output logic                          m_axis_tuser,
  output logic                          m_axis_tlast
);
  import pfrc_pkg::*;

  logic [31:0] frame_size_q;
  logic        copy_to_host_q;
  logic        room;
  push_t       push;
  result_t     head;

  // Configuration registers; an index outside the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_size_q   <= FrameSizeReset;
      copy_to_host_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_FRAME_SIZE:   frame_size_q   <= cfg_wdata_i[31:0];
        REG_COPY_TO_HOST: copy_to_host_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  pfrc_engine #(
    .ADDR_BITS (ADDR_BITS)
  ) u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_addr_i      (s_axis_tdata[47:0]),
    .in_len_i       (s_axis_tdata[63:48]),
    .in_marker_i    (s_axis_tlast),
    .frame_size_i   (frame_size_q),
    .copy_to_host_i (copy_to_host_q),
    .room_i         (room),
    .push_o         (push)
  );

  pfrc_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (head)
  );

  // Pack the head result onto the stream fields.
  assign m_axis_tdata = {4'b0000, head.error_code, head.frame_done, head.copy_host,
                         head.copy_len, head.copy_dest_offset, head.copy_src_addr};
  assign m_axis_tuser = head.copy_valid;
  assign m_axis_tlast = head.last_result;

endmodule
